// ===== rtl/core/cscan_disk_scheduler_assert.svh =====
// ----------------------------------------------------------------------------
// cscan_disk_scheduler assertion macros
// shared property forms for the scheduler checkers
// ----------------------------------------------------------------------------
`ifndef CSCAN_DISK_SCHEDULER_ASSERT_SVH
`define CSCAN_DISK_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define CSCAN_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CSCAN_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/cscan_pkg.sv =====
// ----------------------------------------------------------------------------
// cscan_pkg
// shared constants and types of the C-SCAN disk scheduler
// ----------------------------------------------------------------------------
package cscan_pkg;

   localparam int MAX_REQUESTS  = 32;
   localparam int CYLINDER_BITS = 16;
   localparam int SEEK_W        = 18;
   localparam int CNT_W         = $clog2(MAX_REQUESTS + 1);
   localparam int IDX_W         = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

   localparam logic [15:0] DISK_END_RESET = 16'd199;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_RUN  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HEAD,
      ST_SCAN_A,
      ST_END1,
      ST_END2,
      ST_SCAN_B,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic load;
      logic run;
      logic visit_head;
      logic visit_scan;
      logic phase_b;
      logic visit_first_end;
      logic visit_second_end;
      logic scan_reset;
      logic scan_step;
      logic flush;
   } ctrl_type;

   typedef struct packed {
      logic count_zero;
      logic scan_last;
   } status_type;

endpackage

// ===== rtl/core/cscan_disk_scheduler.sv =====
// ----------------------------------------------------------------------------
// cscan_disk_scheduler
// C-SCAN disk request scheduler: loads requests, then emits the sweep order
// ----------------------------------------------------------------------------
// channel   dir  handshake               payload
// req       in   start & !busy           req_cmd, req_request_cylinder,
//                                        req_head_start, req_prev_position
// rsp       out  rsp_valid (strobe)      rsp_position, rsp_seek_sum, rsp_last
// csr       in   csr_valid & csr_ready   csr_disk_end
//
// a load leaves busy low, so loads can follow every cycle
// a run keeps busy high while the scan counter walks the sorted store twice,
// one entry per cycle
// a visit's result goes out the cycle after the following visit or the flush,
// so the final one carries last; it shows in the same cycle that busy falls
// reset is synchronous; the store needs no clearing pass
// results are strobes and cannot be held off
// ----------------------------------------------------------------------------
module cscan_disk_scheduler (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_cmd,
   input  logic [cscan_pkg::CYLINDER_BITS-1:0] req_request_cylinder,
   input  logic [cscan_pkg::CYLINDER_BITS-1:0] req_head_start,
   input  logic [cscan_pkg::CYLINDER_BITS-1:0] req_prev_position,
   output logic                                rsp_valid,
   output logic [cscan_pkg::CYLINDER_BITS-1:0] rsp_position,
   output logic [cscan_pkg::SEEK_W-1:0]        rsp_seek_sum,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cscan_pkg::CYLINDER_BITS-1:0] csr_disk_end
);
   import cscan_pkg::*;

   ctrl_type   ctrl;
   status_type status;

   assign csr_ready = !busy;

   cscan_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_cmd),
      .status  (status),
      .ctrl    (ctrl),
      .busy    (busy)
   );

   cscan_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .ctrl                 (ctrl),
      .status               (status),
      .req_request_cylinder (req_request_cylinder),
      .req_head_start       (req_head_start),
      .req_prev_position    (req_prev_position),
      .csr_write            (csr_valid && csr_ready),
      .csr_disk_end         (csr_disk_end),
      .rsp_valid            (rsp_valid),
      .rsp_position         (rsp_position),
      .rsp_seek_sum         (rsp_seek_sum),
      .rsp_last             (rsp_last)
   );

endmodule

// ===== rtl/core/cscan_ctrl.sv =====
// ----------------------------------------------------------------------------
// cscan_ctrl
// sequencer for load and run commands of the C-SCAN scheduler
// ----------------------------------------------------------------------------
module cscan_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 req_cmd,
   input  cscan_pkg::status_type status,
   output cscan_pkg::ctrl_type   ctrl,
   output logic                 busy
);
   import cscan_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start && req_cmd == CMD_RUN) state_in = ST_HEAD;
         end
         ST_HEAD: begin
            state_in = status.count_zero ? ST_END1 : ST_SCAN_A;
         end
         ST_SCAN_A: begin
            if (status.scan_last) state_in = ST_END1;
         end
         ST_END1: begin
            state_in = ST_END2;
         end
         ST_END2: begin
            state_in = status.count_zero ? ST_FLUSH : ST_SCAN_B;
         end
         ST_SCAN_B: begin
            if (status.scan_last) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy      = 1'b0;
            ctrl.load = start && req_cmd == CMD_LOAD;
            ctrl.run  = start && req_cmd == CMD_RUN;
         end
         ST_HEAD: begin
            ctrl.visit_head = 1'b1;
            ctrl.scan_reset = 1'b1;
         end
         ST_SCAN_A: begin
            ctrl.visit_scan = 1'b1;
            ctrl.scan_step  = 1'b1;
         end
         ST_END1: begin
            ctrl.visit_first_end = 1'b1;
            ctrl.scan_reset      = 1'b1;
         end
         ST_END2: begin
            ctrl.visit_second_end = 1'b1;
         end
         ST_SCAN_B: begin
            ctrl.visit_scan = 1'b1;
            ctrl.phase_b    = 1'b1;
            ctrl.scan_step  = 1'b1;
         end
         ST_FLUSH: begin
            ctrl.flush = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

// ===== rtl/core/cscan_dp.sv =====
// ----------------------------------------------------------------------------
// cscan_dp
// sorted request store, sweep scan and seek accumulator
// ----------------------------------------------------------------------------
module cscan_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  cscan_pkg::ctrl_type                    ctrl,
   output cscan_pkg::status_type                  status,
   input  logic [cscan_pkg::CYLINDER_BITS-1:0]    req_request_cylinder,
   input  logic [cscan_pkg::CYLINDER_BITS-1:0]    req_head_start,
   input  logic [cscan_pkg::CYLINDER_BITS-1:0]    req_prev_position,
   input  logic                                   csr_write,
   input  logic [cscan_pkg::CYLINDER_BITS-1:0]    csr_disk_end,
   output logic                                   rsp_valid,
   output logic [cscan_pkg::CYLINDER_BITS-1:0]    rsp_position,
   output logic [cscan_pkg::SEEK_W-1:0]           rsp_seek_sum,
   output logic                                   rsp_last
);
   import cscan_pkg::*;

   // request store, kept in ascending order by inserting each load in place
   logic [CYLINDER_BITS-1:0] store_ff [MAX_REQUESTS];
   logic [CYLINDER_BITS-1:0] store_in [MAX_REQUESTS];
   logic [MAX_REQUESTS-1:0]  gt;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CYLINDER_BITS-1:0] disk_end_ff, disk_end_in;
   logic [CYLINDER_BITS-1:0] clamped;
   logic                     full;

   logic [CYLINDER_BITS-1:0] head_ff, head_in;
   logic                     up_ff, up_in;
   logic [IDX_W-1:0]         k_ff, k_in;
   logic [CNT_W-1:0]         rev_idx;
   logic [IDX_W-1:0]         idx;
   logic [CYLINDER_BITS-1:0] elem;
   logic                     in_pass;

   logic [CYLINDER_BITS-1:0] cur_ff, cur_in;
   logic [SEEK_W-1:0]        seek_ff, seek_in;
   logic [CYLINDER_BITS-1:0] pend_pos_ff, pend_pos_in;
   logic [SEEK_W-1:0]        pend_seek_ff, pend_seek_in;
   logic                     visit;
   logic [CYLINDER_BITS-1:0] visit_pos;
   logic [CYLINDER_BITS-1:0] step_len;
   logic [SEEK_W:0]          sum;
   logic [SEEK_W-1:0]        new_seek;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CYLINDER_BITS-1:0] rsp_pos_ff, rsp_pos_in;
   logic [SEEK_W-1:0]        rsp_seek_ff, rsp_seek_in;
   logic                     rsp_last_ff, rsp_last_in;

   // ---------------- load path ----------------
   assign clamped = (req_request_cylinder > disk_end_ff) ? disk_end_ff : req_request_cylinder;
   assign full    = (count_ff == CNT_W'(MAX_REQUESTS));

   always_comb begin
      for (int i = 0; i < MAX_REQUESTS; i++) begin
         gt[i] = (CNT_W'(i) < count_ff) && (store_ff[i] > clamped);
      end
      for (int i = 0; i < MAX_REQUESTS; i++) begin
         store_in[i] = store_ff[i];
         if (ctrl.load && !full && (gt[i] || CNT_W'(i) == count_ff)) begin
            if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
               store_in[i] = store_ff[(i > 0) ? i - 1 : 0];
            end else begin
               store_in[i] = clamped;
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.flush) begin
         count_in = '0;
      end else if (ctrl.load && !full) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   assign disk_end_in = csr_write ? csr_disk_end : disk_end_ff;

   // ---------------- scan path ----------------
   assign head_in = ctrl.run ? req_head_start : head_ff;
   assign up_in   = ctrl.run ? (req_prev_position < req_head_start) : up_ff;

   always_comb begin
      k_in = k_ff;
      if (ctrl.scan_reset) begin
         k_in = '0;
      end else if (ctrl.scan_step) begin
         k_in = k_ff + IDX_W'(1);
      end
   end

   assign rev_idx = count_ff - CNT_W'(1) - CNT_W'(k_ff);
   assign idx     = up_ff ? k_ff : rev_idx[IDX_W-1:0];
   assign elem    = store_ff[idx];

   // up: first pass takes entries at or above the head, second the rest; down: first pass takes entries below the head
   assign in_pass = (elem >= head_ff) ^ ctrl.phase_b ^ !up_ff;

   assign status.count_zero = (count_ff == '0);
   assign status.scan_last  = (CNT_W'(k_ff) == count_ff - CNT_W'(1));

   // ---------------- seek accumulation ----------------
   always_comb begin
      visit     = 1'b0;
      visit_pos = head_ff;
      if (ctrl.visit_head) begin
         visit = 1'b1;
      end else if (ctrl.visit_scan) begin
         visit     = in_pass;
         visit_pos = elem;
      end else if (ctrl.visit_first_end) begin
         visit     = 1'b1;
         visit_pos = up_ff ? disk_end_ff : '0;
      end else if (ctrl.visit_second_end) begin
         visit     = 1'b1;
         visit_pos = up_ff ? '0 : disk_end_ff;
      end
   end

   assign step_len = (cur_ff > visit_pos) ? cur_ff - visit_pos : visit_pos - cur_ff;
   assign sum      = {1'b0, seek_ff} + (SEEK_W + 1)'(step_len);
   assign new_seek = sum[SEEK_W] ? '1 : sum[SEEK_W-1:0];

   always_comb begin
      cur_in       = cur_ff;
      seek_in      = seek_ff;
      pend_pos_in  = pend_pos_ff;
      pend_seek_in = pend_seek_ff;
      if (ctrl.run) begin
         cur_in  = req_head_start;
         seek_in = '0;
      end else if (visit) begin
         cur_in       = visit_pos;
         seek_in      = new_seek;
         pend_pos_in  = visit_pos;
         pend_seek_in = new_seek;
      end
   end

   // the newest visit is held until the next visit or the flush so the final one can carry last
   always_comb begin
      rsp_valid_in = 1'b0;
      rsp_pos_in   = rsp_pos_ff;
      rsp_seek_in  = rsp_seek_ff;
      rsp_last_in  = rsp_last_ff;
      if ((visit && !ctrl.visit_head) || ctrl.flush) begin
         rsp_valid_in = 1'b1;
         rsp_pos_in   = pend_pos_ff;
         rsp_seek_in  = pend_seek_ff;
         rsp_last_in  = ctrl.flush;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         disk_end_ff  <= DISK_END_RESET[CYLINDER_BITS-1:0];
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         disk_end_ff  <= disk_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      store_ff     <= store_in;
      head_ff      <= head_in;
      up_ff        <= up_in;
      k_ff         <= k_in;
      cur_ff       <= cur_in;
      seek_ff      <= seek_in;
      pend_pos_ff  <= pend_pos_in;
      pend_seek_ff <= pend_seek_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_seek_ff  <= rsp_seek_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_seek_sum = rsp_seek_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

// ===== rtl/core/cscan_checker.sv =====
// ----------------------------------------------------------------------------
// cscan_checker
// port-level checks on the scheduler's command and result timing
// ----------------------------------------------------------------------------
`include "cscan_disk_scheduler_assert.svh"

module cscan_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_cmd,
   input logic rsp_valid,
   input logic rsp_last
);
   import cscan_pkg::*;

   `CSCAN_ASSERT_NEXT(a_load_stays_idle, clock, reset, start && !busy && req_cmd == CMD_LOAD, !busy, "load made the block busy")
   `CSCAN_ASSERT_NEXT(a_run_goes_busy, clock, reset, start && !busy && req_cmd == CMD_RUN, busy, "run did not start")
   `CSCAN_ASSERT_NEXT(a_last_ends_run, clock, reset, rsp_valid && rsp_last, !rsp_valid, "result after final transfer")
   `CSCAN_ASSERT_SAME(a_no_result_idle, clock, reset, !busy && $past(!busy), !rsp_valid, "result while idle")

endmodule

bind cscan_disk_scheduler cscan_checker u_cscan_checker (.*);
